### hdl/sha1md_pkg.sv
package sha1md_pkg;

    // initial chaining values
    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // round constants, one per group of twenty rounds
    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [5:0] POS_FULL   = 6'd63;
    localparam logic [5:0] POS_LEN    = 6'd56;
    localparam logic [2:0] WORD_LAST  = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic       load_byte;   // shift in a message byte, count it
        logic       shift_pad;   // shift in the 0x80 marker
        logic       shift_zero;  // shift in a zero fill byte
        logic       shift_len;   // shift in the 64-bit bit length
        logic       load_vars;   // copy chain into working variables
        logic       round;       // one compression round
        logic       fold;        // add working variables into chain
        logic       finish;      // back to initial chain, count cleared
        logic [2:0] word_sel;    // digest word on the output
    } sha1md_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pos_full;    // 63 bytes held, next one completes the block
        logic pos_len;     // 56 bytes held, room for the length
        logic round_last;  // round 79 in progress
    } sha1md_status_t;

endpackage

### hdl/sha1md_dp.sv
module sha1md_dp
    import sha1md_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  sha1md_cmd_t    cmd,
    input  logic [7:0]     data_byte,
    output sha1md_status_t status,
    output logic [31:0]    digest_word
);

    // block and schedule window, word 0 in the top bits
    logic [511:0] blk_reg, blk_next;
    logic [31:0]  vars_reg [5];
    logic [31:0]  chain_reg [5];
    logic [63:0]  count_reg;
    logic [5:0]   pos_reg;
    logic [6:0]   round_reg;

    logic [7:0]   shift_byte;
    logic [31:0]  w_0, w_2, w_8, w_13, w_mix, w_new;
    logic [31:0]  f_val, k_val, t_val;
    logic [63:0]  bit_len;

    assign w_0   = blk_reg[511:480];
    assign w_2   = blk_reg[447:416];
    assign w_8   = blk_reg[255:224];
    assign w_13  = blk_reg[95:64];
    assign w_mix = w_13 ^ w_8 ^ w_2 ^ w_0;
    assign w_new = {w_mix[30:0], w_mix[31]};

    assign bit_len = {count_reg[60:0], 3'b000};

    // byte entering the block
    always_comb begin
        if (cmd.load_byte) begin
            shift_byte = data_byte;
        end else if (cmd.shift_pad) begin
            shift_byte = PAD_BYTE;
        end else begin
            shift_byte = 8'h00;
        end
    end

    // block register: byte shift, length shift or schedule step
    always_comb begin
        blk_next = blk_reg;
        if (cmd.round) begin
            blk_next = {blk_reg[479:0], w_new};
        end else if (cmd.shift_len) begin
            blk_next = {blk_reg[447:0], bit_len};
        end else if (cmd.load_byte || cmd.shift_pad || cmd.shift_zero) begin
            blk_next = {blk_reg[503:0], shift_byte};
        end
    end

    // round function and constant
    always_comb begin
        if (round_reg < 7'd20) begin
            f_val = (vars_reg[1] & vars_reg[2]) | (~vars_reg[1] & vars_reg[3]);
            k_val = K_0;
        end else if (round_reg < 7'd40) begin
            f_val = vars_reg[1] ^ vars_reg[2] ^ vars_reg[3];
            k_val = K_1;
        end else if (round_reg < 7'd60) begin
            f_val = (vars_reg[1] & vars_reg[2]) | (vars_reg[1] & vars_reg[3])
                  | (vars_reg[2] & vars_reg[3]);
            k_val = K_2;
        end else begin
            f_val = vars_reg[1] ^ vars_reg[2] ^ vars_reg[3];
            k_val = K_3;
        end
    end

    assign t_val = {vars_reg[0][26:0], vars_reg[0][31:27]} + f_val + vars_reg[4]
                 + k_val + w_0;

    // payload registers
    always_ff @(posedge aclk) begin
        blk_reg <= blk_next;
        if (cmd.load_vars) begin
            for (int i = 0; i < 5; i++) begin
                vars_reg[i] <= chain_reg[i];
            end
        end else if (cmd.round) begin
            vars_reg[0] <= t_val;
            vars_reg[1] <= vars_reg[0];
            vars_reg[2] <= {vars_reg[1][1:0], vars_reg[1][31:2]};
            vars_reg[3] <= vars_reg[2];
            vars_reg[4] <= vars_reg[3];
        end
    end

    // chain, counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 5; i++) begin
                chain_reg[i] <= H_INIT[i];
            end
            count_reg <= '0;
            pos_reg   <= '0;
            round_reg <= '0;
        end else begin
            if (cmd.finish) begin
                for (int i = 0; i < 5; i++) begin
                    chain_reg[i] <= H_INIT[i];
                end
            end else if (cmd.fold) begin
                for (int i = 0; i < 5; i++) begin
                    chain_reg[i] <= chain_reg[i] + vars_reg[i];
                end
            end

            if (cmd.finish) begin
                count_reg <= '0;
            end else if (cmd.load_byte) begin
                count_reg <= count_reg + 64'd1;
            end

            if (cmd.finish) begin
                pos_reg <= '0;
            end else if (cmd.shift_len) begin
                pos_reg <= pos_reg + 6'd8;
            end else if (cmd.load_byte || cmd.shift_pad || cmd.shift_zero) begin
                pos_reg <= pos_reg + 6'd1;
            end

            if (cmd.load_vars) begin
                round_reg <= '0;
            end else if (cmd.round) begin
                round_reg <= round_reg + 7'd1;
            end
        end
    end

    assign status.pos_full   = (pos_reg == POS_FULL);
    assign status.pos_len    = (pos_reg == POS_LEN);
    assign status.round_last = (round_reg == ROUND_LAST);

    // digest word select
    always_comb begin
        unique case (cmd.word_sel)
            3'd0:    digest_word = chain_reg[0];
            3'd1:    digest_word = chain_reg[1];
            3'd2:    digest_word = chain_reg[2];
            3'd3:    digest_word = chain_reg[3];
            default: digest_word = chain_reg[4];
        endcase
    end

endmodule

### hdl/sha1md_ctrl.sv
module sha1md_ctrl
    import sha1md_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_byte_valid,
    input  logic           s_last,
    output logic           s_ready,
    input  logic           m_ready,
    output logic           m_valid,
    output logic           m_last,
    output logic [2:0]     word_idx,
    input  sha1md_status_t status,
    output sha1md_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_ZERO,
        ST_LEN,
        ST_OUT
    } state_t;

    state_t     state_reg, state_next;
    state_t     after_reg, after_next;
    logic [2:0] idx_reg, idx_next;

    // next state and datapath commands
    always_comb begin
        state_next = state_reg;
        after_next = after_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.word_sel = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_byte = s_byte_valid;
                    if (s_byte_valid && status.pos_full) begin
                        cmd.load_vars = 1'b1;
                        state_next    = ST_ROUND;
                        after_next    = s_last ? ST_PAD : ST_IDLE;
                    end else if (s_last) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND: begin
                cmd.round = 1'b1;
                if (status.round_last) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                cmd.fold   = 1'b1;
                state_next = after_reg;
            end
            ST_PAD: begin
                cmd.shift_pad = 1'b1;
                state_next    = ST_ZERO;
                if (status.pos_full) begin
                    cmd.load_vars = 1'b1;
                    state_next    = ST_ROUND;
                    after_next    = ST_ZERO;
                end
            end
            ST_ZERO: begin
                if (status.pos_len) begin
                    state_next = ST_LEN;
                end else begin
                    cmd.shift_zero = 1'b1;
                    if (status.pos_full) begin
                        cmd.load_vars = 1'b1;
                        state_next    = ST_ROUND;
                        after_next    = ST_ZERO;
                    end
                end
            end
            ST_LEN: begin
                cmd.shift_len = 1'b1;
                cmd.load_vars = 1'b1;
                state_next    = ST_ROUND;
                after_next    = ST_OUT;
                idx_next      = '0;
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (idx_reg == WORD_LAST) begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            after_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            after_reg <= after_next;
            idx_reg   <= idx_next;
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = (state_reg == ST_OUT);
    assign m_last   = (state_reg == ST_OUT) && (idx_reg == WORD_LAST);
    assign word_idx = idx_reg;

endmodule

### hdl/sha1_message_digest_unit.sv
// channel  | dir | tdata                              | tuser      | tlast
// ---------+-----+------------------------------------+------------+------------
// s_       | in  | [7:0] data_byte                    | byte_valid | end message
// m_       | out | [31:0] digest_word, [34:32] index  | -          | fifth word
//
// message bytes are taken while s_tready is high; every 64th byte starts a compression
// of 80 rounds plus a fold step, done by the single round unit.
// the end of a message takes padding, a length step, one or two compressions
// and five output beats.
// reset is synchronous on aresetn low and loads the initial chain.
// s_tready is low during compression, padding and digest output; a low m_tready
// holds the current digest word.
module sha1_message_digest_unit
    import sha1md_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_valid
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_tlast
);

    sha1md_cmd_t    cmd;
    sha1md_status_t status;
    logic [2:0]     word_idx;
    logic [31:0]    digest_word;

    // sequencer
    sha1md_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_tvalid),
        .s_byte_valid (s_tuser),
        .s_last       (s_tlast),
        .s_ready      (s_tready),
        .m_ready      (m_tready),
        .m_valid      (m_tvalid),
        .m_last       (m_tlast),
        .word_idx     (word_idx),
        .status       (status),
        .cmd          (cmd)
    );

    // block, schedule, rounds and chain
    sha1md_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .data_byte   (s_tdata),
        .status      (status),
        .digest_word (digest_word)
    );

    assign m_tdata = {5'b00000, word_idx, digest_word};

endmodule

### hdl/sha1md_chk.sv
module sha1md_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    // no new input while a digest is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_tvalid && s_tready))
        else $error("input ready while digest pending");

    // last beat carries word four
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[34:32] == 3'd4))
        else $error("tlast on wrong digest word");

    // words follow in order
    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && (m_tdata[34:32] == 3'($past(m_tdata[34:32]) + 3'd1))))
        else $error("digest word order broken");

    // after the fifth beat the block takes input again
    a_back_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("not idle after digest");

    // stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled beat changed");

endmodule

bind sha1_message_digest_unit sha1md_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### test/sha1_message_digest_unit_tb.sv
`timescale 1ns / 100ps

module sha1_message_digest_unit_tb;
    import sha1md_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 400;
    localparam int PHASE_ITEMS  = 52;
    localparam int NOISE_PCT    = 10;

    // one digest word as it should leave the block
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [39:0] m_tdata;
    logic        m_tlast;

    // hash state mirrored from the accepted beats
    logic [31:0] chain_h [5];
    logic [31:0] block_w [16];
    logic [63:0] msg_len;

    digest_beat_t digest_q[$];

    int fail_count   = 0;
    int idle_pct     = 0;
    int stall_pct    = 0;
    int stall_cycles = 0;
    int items_sent   = 0;

    sha1_message_digest_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [31:0] rotl(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // big-endian byte placement inside the block
    task automatic insert_byte(int pos, logic [7:0] b);
        int wi;
        int sh;
        wi = (pos >> 2) & 15;
        sh = (3 - (pos & 3)) * 8;
        block_w[wi][sh +: 8] = b;
    endtask

    // 80 rounds over the current block, folded into the chain
    task automatic compress_chain();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, wt, t;
        foreach (w[i]) w[i] = block_w[i];
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 16) begin
                wt = w[r];
            end else begin
                wt = rotl(w[(r - 3) & 15] ^ w[(r - 8) & 15] ^
                          w[(r - 14) & 15] ^ w[r & 15], 1);
                w[r & 15] = wt;
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = K_0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K_1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_2;
            end else begin
                f = b ^ c ^ d;
                k = K_3;
            end
            t = rotl(a, 5) + f + e + k + wt;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] = chain_h[0] + a;
        chain_h[1] = chain_h[1] + b;
        chain_h[2] = chain_h[2] + c;
        chain_h[3] = chain_h[3] + d;
        chain_h[4] = chain_h[4] + e;
    endtask

    // absorb one accepted beat, queue the digest words it finishes
    task automatic absorb_item(logic [7:0] data, logic valid, logic last);
        int pos;
        logic [63:0] bits;
        digest_beat_t beat;
        if (valid) begin
            insert_byte(int'(msg_len[5:0]), data);
            msg_len = msg_len + 64'd1;
            if (msg_len[5:0] == 6'd0)
                compress_chain();
        end
        if (last) begin
            pos = int'(msg_len[5:0]);
            insert_byte(pos, PAD_BYTE);
            for (int i = pos + 1; i < 64; i++)
                insert_byte(i, 8'h00);
            // no room left for the length: one more block
            if (pos >= int'(POS_LEN)) begin
                compress_chain();
                foreach (block_w[i]) block_w[i] = '0;
            end
            bits = msg_len << 3;
            block_w[14] = bits[63:32];
            block_w[15] = bits[31:0];
            compress_chain();
            for (int i = 0; i < 5; i++) begin
                beat.word  = chain_h[i];
                beat.index = 3'(i);
                beat.last  = (i == int'(WORD_LAST));
                digest_q.push_back(beat);
            end
            foreach (chain_h[i]) chain_h[i] = H_INIT[i];
            msg_len = '0;
        end
    endtask

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // one input beat, with random idle cycles ahead of it
    task automatic send_beat(logic [7:0] data, logic valid, logic last);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= valid;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        absorb_item(data, valid, last);
        items_sent++;
    endtask

    // a message of random bytes, sometimes closed by an empty beat
    task automatic send_message(int len);
        logic end_empty;
        end_empty = (len == 0) || ($urandom_range(3) == 0);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < NOISE_PCT)
                send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(8'($urandom), 1'b1, (i == len - 1) && !end_empty);
        end
        if (end_empty)
            send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic test_empty_message();
        send_beat(8'hA5, 1'b0, 1'b1);
    endtask

    task automatic test_abc_vector();
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b1);
    endtask

    // byte extremes, ignored beats and both ways of ending a message
    task automatic test_byte_extremes();
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b0, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'h80, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'hFF, 1'b1, 1'b1);
        send_beat(8'h00, 1'b1, 1'b1);
    endtask

    // one message at a block or padding boundary, then short random messages
    task automatic test_random_traffic(int idle, int stall, int bound_len);
        int start;
        int left;
        int len;
        idle_pct  = idle;
        stall_pct = stall;
        start     = items_sent;
        send_message(bound_len);
        while (items_sent - start < PHASE_ITEMS) begin
            left = PHASE_ITEMS - (items_sent - start);
            len  = $urandom_range(12);
            if (len > left)
                len = left;
            send_message(len);
        end
    endtask

    // receiver backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // digest beat check
    always @(posedge aclk) begin
        digest_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (digest_q.size() == 0) begin
                report_mismatch($sformatf("unexpected digest beat %h", m_tdata));
            end else begin
                want = digest_q.pop_front();
                if (m_tdata[31:0] != want.word)
                    report_mismatch($sformatf("word %0d: got %h want %h",
                                    want.index, m_tdata[31:0], want.word));
                if (m_tdata[34:32] != want.index)
                    report_mismatch($sformatf("index: got %0d want %0d",
                                    m_tdata[34:32], want.index));
                if (m_tlast != want.last)
                    report_mismatch($sformatf("word %0d: tlast got %b want %b",
                                    want.index, m_tlast, want.last));
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // main sequence
    initial begin
        foreach (chain_h[i]) chain_h[i] = H_INIT[i];
        foreach (block_w[i]) block_w[i] = '0;
        msg_len = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_message();
        test_abc_vector();
        test_byte_extremes();
        test_random_traffic(0, 0, 63);
        test_random_traffic(73, 0, 55);
        test_random_traffic(0, 73, 64);
        test_random_traffic(18, 18, 56);
        s_tvalid <= 1'b0;

        while (digest_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
